[hdl/png_hs_pkg.sv]
// ----------------------------------------------------------------------------
// png_hs_pkg
// Shared types and constants for the png header scanner: transaction
// payloads, result status codes and the reset value of the pixel limit.
// ----------------------------------------------------------------------------
package png_hs_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_PIXEL_LIMIT = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_INPUT_ERROR = 3'd4
  } status_e;

  // pixel limit after reset
  localparam logic [31:0] MAX_PIXELS_RST = 32'd4194304;

  // one input transaction: a byte of the file stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    status_e     status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [2:0]  bytes_per_pixel;
    logic [31:0] row_stride;
    logic [31:0] idat_offset;
  } res_item_t;

endpackage

[hdl/png_hs_scan.sv]
// ----------------------------------------------------------------------------
// png_hs_scan
// Per-byte scan engine: signature check, chunk header parse, IHDR capture
// and validation, chunk skipping, and result generation at the first IDAT or on an error.
// ----------------------------------------------------------------------------
module png_hs_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_go_i,
  input  png_hs_pkg::in_item_t  item_i,
  input  logic [31:0]           max_pixels_i,
  output logic                  res_valid_o,
  output png_hs_pkg::res_item_t res_o
);

  // scan phases
  localparam logic [1:0] PH_SIG  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_IHDR = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] IHDR_LEN  = 32'd13;

  localparam logic [3:0] SIG_BYTES  = 4'd8;
  localparam logic [3:0] HDR_BYTES  = 4'd8;
  localparam logic [3:0] IHDR_BYTES = 4'd13;
  localparam logic [3:0] LEN_BYTES  = 4'd4;
  localparam logic [3:0] WID_END    = 4'd8;
  localparam logic [3:0] SMALL_END  = 4'd12;

  localparam logic [7:0] BIT_DEPTH_8 = 8'd8;
  localparam logic [7:0] COLOR_RGB   = 8'd2;
  localparam logic [7:0] COLOR_RGBA  = 8'd6;
  localparam logic [32:0] CRC_BYTES  = 33'd4;

  // png signature byte at a given position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h89;
      3'd1:    r = 8'h50;
      3'd2:    r = 8'h4E;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h0D;
      3'd5:    r = 8'h0A;
      3'd6:    r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  // scan state registers
  logic [1:0]  phase_q, phase_d;
  logic [31:0] off_q, off_d;
  logic [3:0]  fc_q, fc_d;
  logic [31:0] len_q, len_d;
  logic [31:0] typ_q, typ_d;
  logic [32:0] skip_q, skip_d;
  logic [31:0] wid_q, wid_d;
  logic [31:0] hgt_q, hgt_d;
  logic [7:0]  small_q [4];
  logic [7:0]  small_d [4];
  logic        seen_q, seen_d;
  logic        dec_q, dec_d;
  logic [63:0] prod_q;

  // state as seen by this byte, after a possible restart
  logic [1:0]  ph_c;
  logic [31:0] off_c;
  logic [3:0]  fc_c;
  logic [31:0] len_c;
  logic [31:0] typ_c;
  logic [32:0] skip_c;
  logic        seen_c;
  logic        dec_c;

  logic [7:0]  b;
  logic [3:0]  fc_inc;
  logic [31:0] len_n;
  logic [31:0] typ_n;
  logic [32:0] skip_n;
  logic        fin;
  png_hs_pkg::status_e fin_status;
  png_hs_pkg::status_e ihdr_status;
  logic [2:0]  bpp;
  logic [31:0] stride;

  assign b = item_i.data_byte;

  // restart view of the state
  always_comb begin
    ph_c   = item_i.first_byte ? PH_SIG : phase_q;
    off_c  = item_i.first_byte ? '0 : off_q;
    fc_c   = item_i.first_byte ? '0 : fc_q;
    len_c  = item_i.first_byte ? '0 : len_q;
    typ_c  = item_i.first_byte ? '0 : typ_q;
    skip_c = item_i.first_byte ? '0 : skip_q;
    seen_c = item_i.first_byte ? 1'b0 : seen_q;
    dec_c  = item_i.first_byte ? 1'b0 : dec_q;
  end

  // ihdr validation, last small field is the current byte
  always_comb begin
    priority if (wid_q == '0 || hgt_q == '0) begin
      ihdr_status = png_hs_pkg::ST_INVALID;
    end else if (prod_q > {32'd0, max_pixels_i}) begin
      ihdr_status = png_hs_pkg::ST_PIXEL_LIMIT;
    end else if (small_q[0] != BIT_DEPTH_8 ||
                 (small_q[1] != COLOR_RGB && small_q[1] != COLOR_RGBA) ||
                 small_q[2] != '0 || small_q[3] != '0 || b != '0) begin
      ihdr_status = png_hs_pkg::ST_UNSUPPORTED;
    end else begin
      ihdr_status = png_hs_pkg::ST_OK;
    end
  end

  // per-byte next state
  always_comb begin
    phase_d    = ph_c;
    off_d      = off_c;
    fc_d       = fc_c;
    len_d      = len_c;
    typ_d      = typ_c;
    skip_d     = skip_c;
    wid_d      = item_i.first_byte ? '0 : wid_q;
    hgt_d      = item_i.first_byte ? '0 : hgt_q;
    for (int i = 0; i < 4; i++) begin
      small_d[i] = item_i.first_byte ? '0 : small_q[i];
    end
    seen_d     = seen_c;
    dec_d      = dec_c;
    fin        = 1'b0;
    fin_status = png_hs_pkg::ST_OK;
    fc_inc     = fc_c + 4'd1;
    len_n      = (fc_c < LEN_BYTES) ? {len_c[23:0], b} : len_c;
    typ_n      = (fc_c < LEN_BYTES) ? typ_c : {typ_c[23:0], b};
    skip_n     = (skip_c != '0) ? skip_c - 33'd1 : skip_c;

    if (item_go_i && !dec_c) begin
      off_d = (off_c == '1) ? off_c : off_c + 32'd1;
      unique case (ph_c)
        PH_SIG: begin
          if (b != magic_byte(fc_c[2:0])) begin
            fin        = 1'b1;
            fin_status = png_hs_pkg::ST_INVALID;
          end else if (fc_inc == SIG_BYTES) begin
            phase_d = PH_HDR;
            fc_d    = '0;
          end else begin
            fc_d = fc_inc;
          end
        end
        PH_HDR: begin
          len_d = len_n;
          typ_d = typ_n;
          fc_d  = fc_inc;
          if (fc_inc == HDR_BYTES) begin
            fc_d = '0;
            priority if (!seen_c) begin
              if (typ_n != TYPE_IHDR || len_n != IHDR_LEN) begin
                fin        = 1'b1;
                fin_status = png_hs_pkg::ST_INVALID;
              end else begin
                phase_d = PH_IHDR;
              end
            end else if (typ_n == TYPE_IDAT) begin
              fin        = 1'b1;
              fin_status = png_hs_pkg::ST_OK;
            end else if (typ_n == TYPE_IEND) begin
              fin        = 1'b1;
              fin_status = png_hs_pkg::ST_INVALID;
            end else begin
              skip_d  = {1'b0, len_n} + CRC_BYTES;
              phase_d = PH_SKIP;
            end
          end
        end
        PH_IHDR: begin
          priority if (fc_c < LEN_BYTES) begin
            wid_d = {wid_q[23:0], b};
          end else if (fc_c < WID_END) begin
            hgt_d = {hgt_q[23:0], b};
          end else if (fc_c < SMALL_END) begin
            small_d[fc_c[1:0]] = b;
          end else begin
            small_d = small_q;
          end
          fc_d = fc_inc;
          if (fc_inc == IHDR_BYTES) begin
            if (ihdr_status != png_hs_pkg::ST_OK) begin
              fin        = 1'b1;
              fin_status = ihdr_status;
            end else begin
              seen_d  = 1'b1;
              fc_d    = '0;
              skip_d  = CRC_BYTES;
              phase_d = PH_SKIP;
            end
          end
        end
        default: begin
          skip_d = skip_n;
          if (skip_n == '0) begin
            phase_d = PH_HDR;
            fc_d    = '0;
          end
        end
      endcase

      // end of stream with no decision yet
      if (item_i.last_byte && !fin) begin
        fin        = 1'b1;
        fin_status = (phase_d == PH_IHDR) ? png_hs_pkg::ST_INPUT_ERROR
                                          : png_hs_pkg::ST_INVALID;
      end
      if (fin) begin
        dec_d = 1'b1;
      end
    end else if (!item_go_i) begin
      // hold everything when no byte is processed
      phase_d = phase_q;
      off_d   = off_q;
      fc_d    = fc_q;
      len_d   = len_q;
      typ_d   = typ_q;
      skip_d  = skip_q;
      wid_d   = wid_q;
      hgt_d   = hgt_q;
      small_d = small_q;
      seen_d  = seen_q;
      dec_d   = dec_q;
    end
  end

  // derived geometry for an ok result
  assign bpp    = (small_q[1] == COLOR_RGBA) ? 3'd4 : 3'd3;
  assign stride = (small_q[1] == COLOR_RGBA) ? {wid_q[29:0], 2'b00}
                                             : {wid_q[30:0], 1'b0} + wid_q;

  // result assembly, fields are zero unless ok
  always_comb begin
    res_valid_o    = fin;
    res_o          = '0;
    res_o.status   = fin_status;
    if (fin_status == png_hs_pkg::ST_OK) begin
      res_o.image_width     = wid_q;
      res_o.image_height    = hgt_q;
      res_o.bytes_per_pixel = bpp;
      res_o.row_stride      = stride;
      res_o.idat_offset     = off_c - 32'd7;
    end
  end

  // pixel count of the captured size, ready well before the last ihdr byte
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(wid_q) * 64'(hgt_q);
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      off_q   <= '0;
      fc_q    <= '0;
      len_q   <= '0;
      typ_q   <= '0;
      skip_q  <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        small_q[i] <= '0;
      end
      seen_q  <= 1'b0;
      dec_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      fc_q    <= fc_d;
      len_q   <= len_d;
      typ_q   <= typ_d;
      skip_q  <= skip_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      small_q <= small_d;
      seen_q  <= seen_d;
      dec_q   <= dec_d;
    end
  end

endmodule

[hdl/png_hs_outq.sv]
// ----------------------------------------------------------------------------
// png_hs_outq
// Two-entry result queue with read and write pointers, so the scan
// keeps taking bytes while a result waits for the consumer.
// ----------------------------------------------------------------------------
module png_hs_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  png_hs_pkg::res_item_t push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output png_hs_pkg::res_item_t out_data_o
);

  png_hs_pkg::res_item_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

endmodule

[hdl/png_header_scan_to_idat_top.sv]
// ----------------------------------------------------------------------------
// png_header_scan_to_idat_top
// PNG stream header scanner: validates signature and IHDR, skips chunks and
// reports geometry and the offset of the first IDAT chunk.
// ----------------------------------------------------------------------------
// The block takes one byte of the file per clock cycle while the result
// queue has room: each transaction is captured in an input register and the
// whole per-byte update (counters, field shifts, IHDR checks) is applied from
// that register, while a two-entry result queue lets bytes keep flowing while
// a result waits on out_stall_i. A result passes from the byte that decides
// it into the result queue, which drives the output. The width times height
// product is taken from a registered multiplier that completes during the
// five small IHDR fields. Write max_pixels only while no scan is in flight.
module png_header_scan_to_idat_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  png_hs_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output png_hs_pkg::res_item_t out_data_o
);

  logic                  in_valid_q, in_valid_d;
  png_hs_pkg::in_item_t  in_item_q;
  logic [31:0]           max_pixels_q;
  logic                  accept;
  logic                  advance;
  logic                  q_full;
  logic                  res_valid;
  png_hs_pkg::res_item_t res;

  // input handshake
  assign in_stall_o = in_valid_q && q_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign advance    = in_valid_q && !q_full;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_data_i;
    end
  end

  // pixel limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pixels_q <= png_hs_pkg::MAX_PIXELS_RST;
    end else if (cfg_we_i) begin
      max_pixels_q <= cfg_wdata_i;
    end
  end

  // scan engine
  png_hs_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_go_i   (advance),
    .item_i      (in_item_q),
    .max_pixels_i(max_pixels_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result queue
  png_hs_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (q_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // a result only comes from a byte that was processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> advance)
    else $error("result without a processed byte");

  // never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !q_full)
    else $error("result queue overflow");

  // a drained full queue frees a slot in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !out_stall_i) |=> !q_full)
    else $error("result queue stays full after a pop");

  // ok results carry rgb or rgba pixel size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == png_hs_pkg::ST_OK) |->
      (out_data_o.bytes_per_pixel == 3'd3 || out_data_o.bytes_per_pixel == 3'd4))
    else $error("ok result with bad pixel size");

endmodule
